// File: rtl/lidar_scan_to_points_assert.svh
// assertion macros for the lidar scan block
`ifndef LIDAR_SCAN_TO_POINTS_ASSERT_SVH
`define LIDAR_SCAN_TO_POINTS_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LSP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define LSP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/lsp_pkg.sv
// package with constants, types and tables for the lidar scan block
`timescale 1ns / 1ps
package lsp_pkg;
    localparam int MaxSamplesDefault = 4096;
    localparam int CordicStagesDefault = 16;
    localparam int StageLimit = 24;

    localparam logic [2:0] ST_KEPT    = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_PAST    = 3'd2;
    localparam logic [2:0] ST_WINDOW  = 3'd3;
    localparam logic [2:0] ST_KEEPOUT = 3'd4;

    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z = 3'd2;
    localparam logic [2:0] REG_MOUNT    = 3'd3;
    localparam logic [2:0] REG_WIN_LOW  = 3'd4;
    localparam logic [2:0] REG_WIN_HIGH = 3'd5;
    localparam logic [2:0] REG_KEEPOUT  = 3'd6;

    localparam logic signed [31:0] ANG_PI      = 32'sd52707179;
    localparam logic signed [31:0] ANG_TWO_PI  = 32'sd105414357;
    localparam logic signed [31:0] ANG_HALF_PI = 32'sd26353589;
    localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;

    // angle 2^-24 rad, 38 bits holds lo*256 + idx*step at the extremes
    typedef logic signed [37:0] angle_t;
    // cordic datapath, Q28.8 with headroom
    typedef logic signed [35:0] cord_t;

    typedef struct packed {
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [23:0] offset_z;
        logic signed [19:0] mount_angle;
        logic signed [19:0] window_low;
        logic signed [19:0] window_high;
        logic [23:0] keepout_radius;
    } cfg_t;

    // classified item between front and back
    typedef struct packed {
        logic [23:0] range_sample;
        logic signed [31:0] phi;
        logic [2:0] status;
        logic last;
    } task_t;

    function automatic logic signed [31:0] atan_at(input int i);
        logic signed [31:0] r;
        case (i)
            0: r = 32'sd13176795;  1: r = 32'sd7778716;  2: r = 32'sd4110060;
            3: r = 32'sd2086331;   4: r = 32'sd1047214;  5: r = 32'sd524117;
            6: r = 32'sd262123;    7: r = 32'sd131069;   8: r = 32'sd65536;
            9: r = 32'sd32768;    10: r = 32'sd16384;   11: r = 32'sd8192;
            12: r = 32'sd4096;    13: r = 32'sd2048;    14: r = 32'sd1024;
            15: r = 32'sd512;     16: r = 32'sd256;     17: r = 32'sd128;
            18: r = 32'sd64;      19: r = 32'sd32;      20: r = 32'sd16;
            21: r = 32'sd8;       22: r = 32'sd4;       23: r = 32'sd2;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction
endpackage

// File: rtl/lsp_front.sv
// front: beam angle, classification and angle reduction, two stages
`timescale 1ns / 1ps
module lsp_front #(
    parameter int MAX_SAMPLES = lsp_pkg::MaxSamplesDefault
) (
    input  logic aclk,
    input  logic aresetn,
    input  lsp_pkg::cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  logic [23:0] range_sample,
    input  logic range_is_nan,
    input  logic [11:0] sample_index,
    input  logic signed [19:0] scan_first_angle,
    input  logic signed [19:0] scan_second_angle,
    input  logic [23:0] angle_step,
    input  logic [23:0] range_floor,
    input  logic [23:0] range_ceiling,
    input  logic last_in_scan,
    output logic out_valid,
    input  logic out_ready,
    output lsp_pkg::task_t out_task
);
    localparam lsp_pkg::angle_t PI_W = lsp_pkg::angle_t'(lsp_pkg::ANG_PI);
    localparam lsp_pkg::angle_t TWO_PI_W = lsp_pkg::angle_t'(lsp_pkg::ANG_TWO_PI);
    localparam lsp_pkg::angle_t THREE_PI_W = PI_W + TWO_PI_W;
    localparam lsp_pkg::angle_t FOUR_PI_W = TWO_PI_W + TWO_PI_W;

    // stage 1 holds angle and partial flags
    logic s1_valid_reg;
    lsp_pkg::angle_t s1_angle_reg;
    logic signed [19:0] s1_hi_reg;
    logic s1_idx_big_reg, s1_bad_reg, s1_last_reg;
    logic [23:0] s1_range_reg;
    logic s2_valid_reg;
    lsp_pkg::task_t s2_task_reg;
    logic adv2, adv1;

    logic signed [19:0] lo, hi;
    logic idx_big;
    always_comb begin
        lo = (scan_first_angle < scan_second_angle) ? scan_first_angle : scan_second_angle;
        hi = (scan_first_angle < scan_second_angle) ? scan_second_angle : scan_first_angle;
        idx_big = ({20'd0, sample_index} >= 32'(MAX_SAMPLES));
    end

    assign adv2 = !s2_valid_reg || out_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv1) begin
            s1_valid_reg <= in_valid;
        end
        if (adv1) begin
            s1_angle_reg <= lsp_pkg::angle_t'({{10{lo[19]}}, lo, 8'd0})
                + lsp_pkg::angle_t'({2'b0, 36'(sample_index) * 36'(angle_step)});
            s1_hi_reg <= hi;
            s1_idx_big_reg <= idx_big;
            s1_bad_reg <= range_is_nan || (range_sample < range_floor)
                || (range_sample > range_ceiling);
            s1_last_reg <= last_in_scan;
            s1_range_reg <= range_sample;
        end
    end

    lsp_pkg::angle_t hi_w, wl_w, wh_w, mnt_w, phi_a;
    logic signed [31:0] phi_r;
    logic [2:0] st;
    always_comb begin
        hi_w = lsp_pkg::angle_t'({{10{s1_hi_reg[19]}}, s1_hi_reg, 8'd0});
        wl_w = lsp_pkg::angle_t'({{10{cfg.window_low[19]}}, cfg.window_low, 8'd0});
        wh_w = lsp_pkg::angle_t'({{10{cfg.window_high[19]}}, cfg.window_high, 8'd0});
        mnt_w = lsp_pkg::angle_t'({{10{cfg.mount_angle[19]}}, cfg.mount_angle, 8'd0});
        if (s1_idx_big_reg || s1_angle_reg > hi_w) st = lsp_pkg::ST_PAST;
        else if (s1_bad_reg) st = lsp_pkg::ST_BAD;
        else if (s1_angle_reg < wl_w || s1_angle_reg > wh_w) st = lsp_pkg::ST_WINDOW;
        else st = lsp_pkg::ST_KEPT;
        // angle plus mount is folded by at most two wraps of 2pi each way
        phi_a = s1_angle_reg + mnt_w;
        if (phi_a > THREE_PI_W) phi_a = phi_a - FOUR_PI_W;
        else if (phi_a > PI_W) phi_a = phi_a - TWO_PI_W;
        else if (phi_a < -THREE_PI_W) phi_a = phi_a + FOUR_PI_W;
        else if (phi_a < -PI_W) phi_a = phi_a + TWO_PI_W;
        phi_r = phi_a[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv2) begin
            s2_task_reg.range_sample <= s1_range_reg;
            s2_task_reg.phi <= phi_r;
            s2_task_reg.status <= st;
            s2_task_reg.last <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_task = s2_task_reg;
endmodule

// File: rtl/lsp_queue.sv
// short fifo between front and back
`timescale 1ns / 1ps
module lsp_queue (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  lsp_pkg::task_t in_task,
    output logic out_valid,
    input  logic out_ready,
    output lsp_pkg::task_t out_task
);
    lsp_pkg::task_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;
    assign in_ready = (cnt_reg != 3'd4);
    assign out_valid = (cnt_reg != 3'd0);
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;
    assign out_task = mem_reg[rp_reg];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
        if (wr) mem_reg[wp_reg] <= in_task;
    end
endmodule

// File: rtl/lsp_back.sv
// back: gain scale, pipelined cordic, offsets and keep-out test
`timescale 1ns / 1ps
module lsp_back #(
    parameter int CORDIC_STAGES = lsp_pkg::CordicStagesDefault
) (
    input  logic aclk,
    input  logic aresetn,
    input  lsp_pkg::cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  lsp_pkg::task_t in_task,
    output logic out_valid,
    input  logic out_ready,
    output logic [23:0] point_x,
    output logic [23:0] point_y,
    output logic [23:0] point_z,
    output logic [2:0] status,
    output logic end_of_scan
);
    localparam int NS = (CORDIC_STAGES > lsp_pkg::StageLimit) ? lsp_pkg::StageLimit
                                                               : CORDIC_STAGES;
    // pipeline: scale, fold, NS cordic, round/offset, square, compare
    localparam int NP = NS + 5;

    logic adv;
    logic [NP-1:0] v_reg;
    assign adv = !v_reg[NP-1] || out_ready;
    assign in_ready = adv;

    // stage 0: multiply range by inverse gain
    logic [47:0] prod0_reg;
    logic signed [31:0] phi0_reg;
    logic [2:0] st_reg [NP];
    logic last_reg [NP];
    // stage 1 .. NS+1 cordic state
    lsp_pkg::cord_t x_reg [NS+1];
    lsp_pkg::cord_t y_reg [NS+1];
    logic signed [31:0] z_reg [NS+1];
    // later stages
    logic signed [23:0] px_reg, py_reg;
    logic [47:0] sx_reg, sy_reg, kk_reg;
    logic signed [23:0] fx_reg, fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NP-2:0], in_valid};
        end
    end

    lsp_pkg::cord_t x0;
    logic signed [31:0] z0;
    always_comb begin
        x0 = lsp_pkg::cord_t'((prod0_reg + 48'd32768) >> 16);
        z0 = phi0_reg;
        if (phi0_reg > lsp_pkg::ANG_HALF_PI) begin
            z0 = phi0_reg - lsp_pkg::ANG_PI;
            x0 = -x0;
        end else if (phi0_reg < -lsp_pkg::ANG_HALF_PI) begin
            z0 = phi0_reg + lsp_pkg::ANG_PI;
            x0 = -x0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod0_reg <= in_task.range_sample * lsp_pkg::INV_GAIN_Q24;
            phi0_reg <= in_task.phi;
            st_reg[0] <= in_task.status;
            last_reg[0] <= in_task.last;
            for (int k = 1; k < NP; k++) begin
                st_reg[k] <= st_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
            x_reg[0] <= x0;
            y_reg[0] <= '0;
            z_reg[0] <= z0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_cord
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (z_reg[g] >= 0) begin
                        x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                        y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                        z_reg[g+1] <= z_reg[g] - lsp_pkg::atan_at(g);
                    end else begin
                        x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                        y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                        z_reg[g+1] <= z_reg[g] + lsp_pkg::atan_at(g);
                    end
                end
            end
        end
    endgenerate

    function automatic logic signed [23:0] sat(input logic signed [29:0] v);
        if (v > 30'sd8388607) return 24'sh7fffff;
        if (v < -30'sd8388608) return -24'sh800000;
        return v[23:0];
    endfunction

    lsp_pkg::cord_t rx, ry;
    always_comb begin
        rx = (x_reg[NS] + 36'sd128) >>> 8;
        ry = (y_reg[NS] + 36'sd128) >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= sat(rx[29:0] + 30'(cfg.offset_x));
            py_reg <= sat(ry[29:0] + 30'(cfg.offset_y));
            sx_reg <= 48'(px_reg * px_reg);
            sy_reg <= 48'(py_reg * py_reg);
            kk_reg <= cfg.keepout_radius * cfg.keepout_radius;
            fx_reg <= px_reg;
            fy_reg <= py_reg;
        end
    end

    // output holding register
    logic [23:0] ox_reg, oy_reg, oz_reg;
    logic [2:0] ost_reg;
    logic olast_reg;
    logic kept;
    assign kept = (st_reg[NP-2] == lsp_pkg::ST_KEPT);
    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg <= kept ? fx_reg : 24'd0;
            oy_reg <= kept ? fy_reg : 24'd0;
            oz_reg <= kept ? cfg.offset_z : 24'd0;
            ost_reg <= (kept && ({1'b0, sx_reg} + {1'b0, sy_reg} < {1'b0, kk_reg}))
                ? lsp_pkg::ST_KEEPOUT : st_reg[NP-2];
            olast_reg <= last_reg[NP-2];
        end
    end

    assign out_valid = v_reg[NP-1];
    assign point_x = ox_reg;
    assign point_y = oy_reg;
    assign point_z = oz_reg;
    assign status = ost_reg;
    assign end_of_scan = olast_reg;
endmodule

// File: rtl/lidar_scan_to_points.sv
// top level: lidar range samples to classified points
// throughput: one item per clock while m_tready does not stall the output; the pipelined cordic sets that rate
// a 4-entry queue parts front and back so each side stalls on its own
// reset: aresetn synchronous active low clears valids, queue and registers
// to their reset values; payload registers are not reset
`timescale 1ns / 1ps
module lidar_scan_to_points #(
    parameter int MAX_SAMPLES = lsp_pkg::MaxSamplesDefault,
    parameter int CORDIC_STAGES = lsp_pkg::CordicStagesDefault
) (
    input  logic aclk,
    input  logic aresetn,
    // configuration write port
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [23:0] cfg_wdata,
    // input channel
    input  logic s_tvalid,
    output logic s_tready,
    // range_sample[23:0], range_is_nan[24], sample_index[36:25],
    // scan_first_angle[56:37], scan_second_angle[76:57], angle_step[100:77],
    // range_floor[124:101], range_ceiling[148:125], zero fill to 152
    input  logic [151:0] s_tdata,
    input  logic s_tlast,
    // result channel
    output logic m_tvalid,
    input  logic m_tready,
    // point_x[23:0], point_y[47:24], point_z[71:48], status[74:72], zero fill to 80
    output logic [79:0] m_tdata,
    output logic m_tlast
);
    // configuration registers
    lsp_pkg::cfg_t cfg_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.offset_z <= '0;
            cfg_reg.mount_angle <= '0;
            cfg_reg.window_low <= -20'sd205887;
            cfg_reg.window_high <= 20'sd205887;
            cfg_reg.keepout_radius <= 24'd13107;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lsp_pkg::REG_OFFSET_X: cfg_reg.offset_x <= cfg_wdata;
                lsp_pkg::REG_OFFSET_Y: cfg_reg.offset_y <= cfg_wdata;
                lsp_pkg::REG_OFFSET_Z: cfg_reg.offset_z <= cfg_wdata;
                lsp_pkg::REG_MOUNT:    cfg_reg.mount_angle <= cfg_wdata[19:0];
                lsp_pkg::REG_WIN_LOW:  cfg_reg.window_low <= cfg_wdata[19:0];
                lsp_pkg::REG_WIN_HIGH: cfg_reg.window_high <= cfg_wdata[19:0];
                lsp_pkg::REG_KEEPOUT:  cfg_reg.keepout_radius <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front to queue
    logic f_valid, f_ready;
    lsp_pkg::task_t f_task;
    // queue to back
    logic q_valid, q_ready;
    lsp_pkg::task_t q_task;

    lsp_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .aclk, .aresetn, .cfg(cfg_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .range_sample(s_tdata[23:0]), .range_is_nan(s_tdata[24]),
        .sample_index(s_tdata[36:25]), .scan_first_angle(s_tdata[56:37]),
        .scan_second_angle(s_tdata[76:57]), .angle_step(s_tdata[100:77]),
        .range_floor(s_tdata[124:101]), .range_ceiling(s_tdata[148:125]),
        .last_in_scan(s_tlast),
        .out_valid(f_valid), .out_ready(f_ready), .out_task(f_task)
    );

    lsp_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_task(f_task),
        .out_valid(q_valid), .out_ready(q_ready), .out_task(q_task)
    );

    lsp_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .aclk, .aresetn, .cfg(cfg_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_task(q_task),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .point_x(m_tdata[23:0]), .point_y(m_tdata[47:24]), .point_z(m_tdata[71:48]),
        .status(m_tdata[74:72]), .end_of_scan(m_tlast)
    );
    assign m_tdata[79:75] = '0;
endmodule

// File: rtl/lsp_checker.sv
// port-level checker for the lidar scan block, bound to the top level
`timescale 1ns / 1ps
`include "lidar_scan_to_points_assert.svh"
module lsp_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_tvalid,
    input logic m_tready,
    input logic [79:0] m_tdata
);
    logic [2:0] st;
    logic dropped;
    assign st = m_tdata[74:72];
    assign dropped = (st == lsp_pkg::ST_BAD) || (st == lsp_pkg::ST_PAST)
        || (st == lsp_pkg::ST_WINDOW);

    `LSP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LSP_ASSERT_IMP(a_status_range, aclk, aresetn, m_tvalid, st <= lsp_pkg::ST_KEEPOUT)
    `LSP_ASSERT_IMP(a_drop_zero, aclk, aresetn, m_tvalid && dropped, m_tdata[71:0] == 72'd0)
    `LSP_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[79:75] == 5'd0)
endmodule

bind lidar_scan_to_points lsp_checker u_lsp_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
);
